@@ sv/ebike_display_link_framer_core_assert.svh @@
// Assertion macros for the display link framer.
// Included by the top level; expects clk and rst_n in scope.
`ifndef EBIKE_DISPLAY_LINK_FRAMER_CORE_ASSERT_SVH
`define EBIKE_DISPLAY_LINK_FRAMER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EBDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EBDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ebdl_pkg.sv @@
// Shared types, constants and the status frame byte table of the display link framer.
// No dependencies; imported by ebdl_div, ebike_display_link_framer_core, ebdl_link_monitor and testbench.
`timescale 1ns / 1ps

package ebdl_pkg;

  // Input word modes.
  localparam logic        MODE_RX_BYTE   = 1'b0;
  localparam logic        MODE_TICK      = 1'b1;

  // Receive framing.
  localparam int          RX_FRAME_BYTES = 20;
  localparam int          POS_W          = 5;
  localparam logic [7:0]  RX_START       = 8'h01;
  localparam logic [7:0]  RX_SECOND      = 8'h14;
  localparam logic [3:0]  LEVEL_MASK     = 4'hF;
  localparam logic [POS_W-1:0] POS_LEVEL = POS_W'(4);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(RX_FRAME_BYTES - 1);

  // Wheel time division.
  localparam int          DVD_W    = 19;
  localparam int          DIV_W    = 13;
  localparam int          CNT_W    = 5;
  localparam logic [DVD_W-1:0] WHEEL_DIVIDEND = DVD_W'(382795);
  localparam logic signed [15:0] SPEED_MIN = 16'sd90;
  localparam logic signed [15:0] SPEED_MAX = 16'sd4557;

  // Status frame.
  localparam int          STATUS_LEN  = 14;
  localparam int          IDX_W       = 4;
  localparam logic [IDX_W-1:0] STATUS_LAST = IDX_W'(STATUS_LEN - 1);
  localparam logic [7:0]  MOTOR_ERR_CODE   = 8'h40;

  // Result kinds.
  localparam logic [1:0]  KIND_STATUS = 2'd0;
  localparam logic [1:0]  KIND_GOOD   = 2'd1;
  localparam logic [1:0]  KIND_BAD    = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [7:0]         rx_byte;
    logic signed [15:0] wheel_speed;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [3:0] assist_level;
    logic       level_changed;
  } out_item_t;

  // Divider control and result between the sequencer and the divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Byte idx of the status frame: 02 0E 01 err 80 00 00 00 wtH wtL 00 00 FF xor.
  // The constant bytes fold to 0x72 in the checksum.
  function automatic logic [7:0] status_byte(input logic [IDX_W-1:0] idx,
                                             input logic             err,
                                             input logic [DIV_W-1:0] wt);
    logic [7:0] err_b;
    logic [7:0] wt_hi;
    logic [7:0] wt_lo;
    logic [7:0] res;
    err_b = err ? MOTOR_ERR_CODE : 8'h00;
    wt_hi = 8'(wt >> 8);
    wt_lo = wt[7:0];
    case (idx)
      4'd0:    res = 8'h02;
      4'd1:    res = 8'h0E;
      4'd2:    res = 8'h01;
      4'd3:    res = err_b;
      4'd4:    res = 8'h80;
      4'd8:    res = wt_hi;
      4'd9:    res = wt_lo;
      4'd12:   res = 8'hFF;
      4'd13:   res = 8'h72 ^ err_b ^ wt_hi ^ wt_lo;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ sv/ebdl_div.sv @@
// Bit-serial restoring divider: the fixed wheel dividend over a clamped speed.
// Depends on ebdl_pkg.
`timescale 1ns / 1ps

module ebdl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  ebdl_pkg::div_req_t req,
  output ebdl_pkg::div_rsp_t rsp
);
  import ebdl_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dsr_r, dsr_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;

  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle; dq shifts dividend bits out and quotient bits in.
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      dq_nxt   = WHEEL_DIVIDEND;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r[DIV_W-1:0];

endmodule

@@ sv/ebike_display_link_framer_core.sv @@
// Top level of the display link framer: receive framing, status frame sequencer.
// Depends on ebdl_pkg, ebdl_div and ebike_display_link_framer_core_assert.svh.
`timescale 1ns / 1ps

// Each input word is either a byte received from the display (mode 0) or a
// service tick carrying the wheel speed (mode 1). The frame hunter looks for
// 0x01 then 0x14, collects a 20-byte frame and, at its last byte, produces
// one word: a good frame report with the assist level from the low nibble of
// byte 4 and a changed flag, or a checksum error. A service tick clamps the
// speed to 90..4557, divides 382795 by it in the bit-serial divider (one
// quotient bit per cycle) and then emits the 14 status frame bytes, one per
// cycle while the output register is free, the last one flagged. in_ready
// stays low while a tick is divided and its bytes are emitted, also while
// the consumer holds out_ready low. Results sit in an output register, and
// a new input word is taken only while that register is empty or is being
// read in the same cycle, so a result that waits holds off the input.
// The motor_error register may be written at any time the block is idle; it
// selects the error byte (0x40 or 0x00) carried in status frame byte 3.

module ebike_display_link_framer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ebdl_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ebdl_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);
  import ebdl_pkg::*;

  `include "ebike_display_link_framer_core_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [3:0]       cap_r, cap_nxt;
  logic [3:0]       assist_r, assist_nxt;
  logic             motor_err_r, motor_err_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [DIV_W-1:0] wt_r, wt_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             in_acc;
  logic             out_free;
  logic [7:0]       rx_b;
  logic signed [15:0] speed;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && out_free;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign rx_b      = in_data.rx_byte;
  assign speed     = in_data.wheel_speed;

  always_comb begin
    div_req.start   = in_acc && (in_data.mode == MODE_TICK);
    div_req.divisor = DIV_W'(SPEED_MIN);
    if (speed > SPEED_MAX) begin
      div_req.divisor = DIV_W'(SPEED_MAX);
    end else if (speed >= SPEED_MIN) begin
      div_req.divisor = speed[DIV_W-1:0];
    end
  end

  ebdl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    xor_nxt       = xor_r;
    cap_nxt       = cap_r;
    assist_nxt    = assist_r;
    motor_err_nxt = motor_err_r;
    idx_nxt       = idx_r;
    wt_nxt        = wt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      motor_err_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.mode == MODE_TICK)) begin
          state_nxt = ST_DIV;
        end else if (in_acc) begin
          if (pos_r == '0) begin
            // Bytes before a start byte are dropped.
            if (rx_b == RX_START) begin
              xor_nxt = rx_b;
              pos_nxt = POS_W'(1);
            end
          end else if (pos_r == POS_W'(1)) begin
            if (rx_b != RX_SECOND) begin
              pos_nxt = '0;
              xor_nxt = '0;
            end else begin
              xor_nxt = xor_r ^ rx_b;
              pos_nxt = POS_W'(2);
            end
          end else if (pos_r >= POS_LAST) begin
            // Frame end: report, then hunt for the next start byte.
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if ((xor_r ^ rx_b) == 8'h00) begin
              out_data_nxt.kind          = KIND_GOOD;
              out_data_nxt.assist_level  = cap_r;
              out_data_nxt.level_changed = (cap_r != assist_r);
              assist_nxt                 = cap_r;
            end else begin
              out_data_nxt.kind = KIND_BAD;
            end
            pos_nxt = '0;
            xor_nxt = '0;
          end else begin
            if (pos_r == POS_LEVEL) begin
              cap_nxt = rx_b[3:0] & LEVEL_MASK;
            end
            xor_nxt = xor_r ^ rx_b;
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          wt_nxt    = div_rsp.quotient;
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt         = '0;
          out_data_nxt.kind    = KIND_STATUS;
          out_data_nxt.tx_byte = status_byte(idx_r, motor_err_r, wt_r);
          out_data_nxt.last    = (idx_r == STATUS_LAST);
          if (idx_r == STATUS_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      xor_r       <= '0;
      cap_r       <= '0;
      assist_r    <= '0;
      motor_err_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      xor_r       <= xor_nxt;
      cap_r       <= cap_nxt;
      assist_r    <= assist_nxt;
      motor_err_r <= motor_err_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wt_r       <= wt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The frame marker only ever closes a status frame.
  `EBDL_ASSERT_NOW(a_last_is_status, out_valid_r && out_data_r.last,
    out_data_r.kind == KIND_STATUS, "last flag on a non-status word")
  // The divider finishes only while the sequencer waits for it.
  `EBDL_ASSERT_NOW(a_done_in_div, div_rsp.done, state_r == ST_DIV,
    "divider done outside the divide state")
  // Wheel time always lies within the range the clamp allows.
  `EBDL_ASSERT_NOW(a_wt_range, div_rsp.done,
    (div_rsp.quotient >= DIV_W'(84)) && (div_rsp.quotient <= DIV_W'(4253)),
    "wheel time out of range")
  // A service tick leaves the receive framing untouched.
  `EBDL_ASSERT_NEXT(a_rx_hold, state_r != ST_IDLE, $stable(pos_r) && $stable(xor_r),
    "receive state moved during a status run")

endmodule

@@ dv/ebdl_link_monitor.sv @@
// Checker for the display link framer: watches the input, result and register channels.
// Predicts every result word and compares it; depends on ebdl_pkg only.
`timescale 1ns / 1ps

module ebdl_link_monitor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ebdl_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ebdl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  output int                  mismatches,
  output int                  pending_words
);
  import ebdl_pkg::*;

  // Shadow copy of the framer state and of the motor error register.
  logic [POS_W-1:0] frame_pos;
  logic [7:0]       frame_xor;
  logic [3:0]       level_seen;
  logic [3:0]       assist_now;
  logic             motor_err;
  int               fail_total;

  out_item_t expected_words[$];

  task automatic take_rx_byte(input logic [7:0] b);
    out_item_t w;
    w = '0;
    if (frame_pos == '0) begin
      if (b == RX_START) begin
        frame_xor = b;
        frame_pos = POS_W'(1);
      end
    end else if (frame_pos == POS_W'(1)) begin
      if (b != RX_SECOND) begin
        frame_pos = '0;
        frame_xor = 8'h00;
      end else begin
        frame_xor = frame_xor ^ b;
        frame_pos = POS_W'(2);
      end
    end else if (frame_pos >= POS_LAST) begin
      if ((frame_xor ^ b) == 8'h00) begin
        w.kind          = KIND_GOOD;
        w.assist_level  = level_seen;
        w.level_changed = (level_seen != assist_now);
        assist_now      = level_seen;
      end else begin
        w.kind = KIND_BAD;
      end
      expected_words.push_back(w);
      frame_pos = '0;
      frame_xor = 8'h00;
    end else begin
      if (frame_pos == POS_LEVEL)
        level_seen = b[3:0] & LEVEL_MASK;
      frame_xor = frame_xor ^ b;
      frame_pos = frame_pos + 1'b1;
    end
  endtask

  task automatic take_tick(input logic signed [15:0] raw_speed);
    int         speed;
    int         wheel_time;
    logic [7:0] status_frame [STATUS_LEN];
    logic [7:0] fold;
    out_item_t  w;
    speed = int'(raw_speed);
    if (speed < int'(SPEED_MIN))
      speed = int'(SPEED_MIN);
    if (speed > int'(SPEED_MAX))
      speed = int'(SPEED_MAX);
    wheel_time = int'(WHEEL_DIVIDEND) / speed;
    for (int i = 0; i < STATUS_LEN; i++)
      status_frame[i] = 8'h00;
    // Header, error byte, fixed marker, wheel time big-endian, trailer.
    status_frame[0]  = 8'h02;
    status_frame[1]  = 8'h0E;
    status_frame[2]  = 8'h01;
    status_frame[3]  = motor_err ? MOTOR_ERR_CODE : 8'h00;
    status_frame[4]  = 8'h80;
    status_frame[8]  = wheel_time[15:8];
    status_frame[9]  = wheel_time[7:0];
    status_frame[12] = 8'hFF;
    fold = 8'h00;
    for (int i = 0; i < STATUS_LEN - 1; i++)
      fold = fold ^ status_frame[i];
    status_frame[STATUS_LEN-1] = fold;
    for (int i = 0; i < STATUS_LEN; i++) begin
      w         = '0;
      w.kind    = KIND_STATUS;
      w.tx_byte = status_frame[i];
      w.last    = (i == STATUS_LEN - 1);
      expected_words.push_back(w);
    end
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_total++;
    end
  endtask

  task automatic check_word(input out_item_t got);
    out_item_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, got kind %0d byte %0h last %0d",
               $time, got.kind, got.tx_byte, got.last);
      $display("%0t: unexpected word carries level %0d chg %0d",
               $time, got.assist_level, got.level_changed);
      fail_total++;
    end else begin
      want = expected_words.pop_front();
      compare_field("kind", 8'(want.kind), 8'(got.kind));
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("last", 8'(want.last), 8'(got.last));
      compare_field("assist_level", 8'(want.assist_level), 8'(got.assist_level));
      compare_field("level_changed", 8'(want.level_changed), 8'(got.level_changed));
    end
  endtask

  // A result accepted at an edge was registered before it, so it is checked
  // before the input word of the same edge adds its own expectations.
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_pos  = '0;
      frame_xor  = 8'h00;
      level_seen = 4'h0;
      assist_now = 4'h0;
      motor_err  = 1'b0;
      fail_total = 0;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready)
        check_word(out_data);
      if (cfg_valid && cfg_ready)
        motor_err = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_RX_BYTE)
          take_rx_byte(in_data.rx_byte);
        else
          take_tick(in_data.wheel_speed);
      end
    end
    mismatches    <= fail_total;
    pending_words <= expected_words.size();
  end

endmodule

@@ dv/testbench.sv @@
// Top of the display link framer testbench: clock, reset, stimulus and verdict.
// Depends on ebdl_pkg, ebike_display_link_framer_core and ebdl_link_monitor.
`timescale 1ns / 1ps

module testbench;
  import ebdl_pkg::*;

  // Roughly how many input words the whole run offers, spread over the phases.
  localparam int RANDOM_WORDS = 370;
  localparam int PHASES       = 4;
  // The tail lets the block finish a tick's status run, with some margin,
  // before a register write or the verdict.
  localparam int TAIL_CYCLES  = 40;
  // The limit is several times the slowest correct run, in which every word is
  // a tick with 14 results at the sparsest ready pattern, with the widest input
  // gaps and the long hold-offs.
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_pattern_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_ready = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_ready;
  logic      out_valid;
  out_item_t out_data;
  logic      cfg_ready;

  int mismatches;
  int pending_words;
  int cycle_count        = 0;
  int long_hold_requests = 0;
  int burst_left         = 0;
  int gap_limit          = 0;
  int word_count         = 0;

  ebike_display_link_framer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ebdl_link_monitor monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The result side runs on its own. It switches at random between four ready
  // patterns, and whenever the stimulus asks for it it holds off completely
  // so that the output register fills and the block has to stall its input.
  initial begin : receiver
    ready_pattern_t pattern;
    int             pattern_left;
    int             holds_done;
    pattern      = READY_ALWAYS;
    pattern_left = 0;
    holds_done   = 0;
    forever begin
      @(posedge clk);
      if (holds_done < long_hold_requests) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat ($urandom_range(250, 400)) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern      = ready_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(20, 120);
        end
        pattern_left--;
        case (pattern)
          READY_ALWAYS: out_ready <= 1'b1;
          READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
          READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:      out_ready <= (pattern_left % 4 != 0);
        endcase
      end
    end
  end

  // Offers one word and returns at the edge where it is taken. Words go out
  // in bursts; before each burst the sender may sit idle for a random gap
  // bounded by gap_limit. Within a burst valid simply stays high.
  task automatic send_word(input in_item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    word_count++;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // The field that a mode does not use is filled at random all the same.
  function automatic in_item_t rx_word(input logic [7:0] b);
    in_item_t w;
    w.mode        = MODE_RX_BYTE;
    w.rx_byte     = b;
    w.wheel_speed = 16'($urandom);
    return w;
  endfunction

  function automatic in_item_t tick_word(input logic signed [15:0] speed);
    in_item_t w;
    w.mode        = MODE_TICK;
    w.rx_byte     = 8'($urandom);
    w.wheel_speed = speed;
    return w;
  endfunction

  // Speeds are spread over the clamp range, both sides of it, negative values
  // and the whole 16-bit range, with the clamp boundaries hit often.
  function automatic logic signed [15:0] pick_speed();
    logic signed [15:0] s;
    case ($urandom_range(0, 5))
      0:       s = 16'($urandom);
      1:       s = 16'($urandom_range(SPEED_MIN, SPEED_MAX));
      2:       s = 16'($urandom_range(0, SPEED_MIN - 1));
      3:       s = 16'(-$signed(17'($urandom_range(1, 32768))));
      4:       s = 16'($urandom_range(SPEED_MAX + 1, 32767));
      default: s = 16'(($urandom_range(0, 1) ? SPEED_MIN : SPEED_MAX)
                       + $urandom_range(0, 2) - 1);
    endcase
    return s;
  endfunction

  // A well-formed frame: start byte, second byte, random body with the level
  // in the low nibble of byte 4, and a checksum that is either right or off.
  // Service ticks are slipped in between frame bytes now and then, since a
  // tick must leave the frame hunter where it was.
  task automatic send_frame(input bit good, input logic [3:0] level);
    logic [7:0] body [RX_FRAME_BYTES];
    logic [7:0] fold;
    body[0] = RX_START;
    body[1] = RX_SECOND;
    fold    = RX_START ^ RX_SECOND;
    for (int i = 2; i < RX_FRAME_BYTES - 1; i++) begin
      body[i] = 8'($urandom);
      if (i == POS_LEVEL)
        body[i][3:0] = level;
      fold = fold ^ body[i];
    end
    if (good)
      body[RX_FRAME_BYTES-1] = fold;
    else if ($urandom_range(0, 1))
      body[RX_FRAME_BYTES-1] = fold ^ (8'h01 << $urandom_range(0, 7));
    else
      body[RX_FRAME_BYTES-1] = fold ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < RX_FRAME_BYTES; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_word(tick_word(pick_speed()));
      send_word(rx_word(body[i]));
    end
  endtask

  // Drops valid and waits for every expected word, then lets the block settle.
  // The first edge makes sure the last accepted word is counted as pending.
  task automatic wait_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_motor_error(input logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int         choice;
    int         target;
    logic [3:0] level;
    logic [7:0] second;
    level = 4'h0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, motor error still at its reset value. Clamp extremes:
    // most negative, zero, just below the floor, the floor, the ceiling and
    // the largest positive speed.
    send_word(tick_word(16'sh8000));
    send_word(tick_word(16'sd0));
    send_word(tick_word(SPEED_MIN - 16'sd1));
    send_word(tick_word(SPEED_MIN));
    send_word(tick_word(SPEED_MAX));
    send_word(tick_word(16'sh7FFF));
    // Bytes before a start byte are dropped.
    send_word(rx_word(8'hFF));
    send_word(rx_word(8'h00));
    // A bad second byte is dropped even when it is itself a start byte.
    send_word(rx_word(RX_START));
    send_word(rx_word(RX_START));
    send_word(rx_word(RX_START));
    send_word(rx_word(8'h55));
    wait_drained();
    write_motor_error(1'b1);
    send_word(tick_word(SPEED_MAX + 16'sd1));
    send_word(tick_word(16'sd1000));
    wait_drained();

    // Random part, in phases with the register alternating between its two
    // values. Phase 0 offers words back to back; the others idle in gaps of
    // differing lengths. Phase 1 also asks the receiver for a long hold-off.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_motor_error(1'(phase % 2));
      case (phase)
        0:       gap_limit = 0;
        1:       gap_limit = 4;
        2:       gap_limit = 20;
        default: gap_limit = 2;
      endcase
      if (phase == 1)
        long_hold_requests <= long_hold_requests + 1;
      if (phase == 0) begin
        // Frame end cases up front: a good frame at the top level, a bad one
        // which must not disturb the level, then the same level again.
        send_frame(1'b1, 4'hF);
        send_frame(1'b0, 4'h3);
        send_frame(1'b1, 4'hF);
      end
      target = (phase + 1) * RANDOM_WORDS / PHASES;
      while (word_count < target) begin
        choice = $urandom_range(0, 99);
        if (choice < 55) begin
          // Repeat the last level now and then, so unchanged reports occur.
          if ($urandom_range(0, 2) != 0)
            level = 4'($urandom);
          send_frame($urandom_range(0, 3) != 0, level);
        end else if (choice < 80) begin
          send_word(tick_word(pick_speed()));
        end else if (choice < 90) begin
          second = 8'($urandom);
          if (second == RX_SECOND)
            second = RX_START;
          send_word(rx_word(RX_START));
          send_word(rx_word(second));
        end else begin
          // Line noise, closed by a zero byte so the hunter ends at rest unless the noise holds 0x01 then 0x14.
          repeat ($urandom_range(1, 4)) send_word(rx_word(8'($urandom)));
          send_word(rx_word(8'h00));
        end
        if ($urandom_range(0, 29) == 0)
          wait_drained();
      end
      wait_drained();
    end

    if (mismatches == 0 && pending_words == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
